### hdl/tcw_pkg.sv
// Shared types, constants and codes for the text console writer.
package tcw_pkg;

  localparam int COLUMNS_DEFAULT = 80;
  localparam int ROWS_DEFAULT    = 25;

  localparam int OP_W      = 2;
  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int INDEX_W   = 11;
  localparam int DATA_W    = 16;
  localparam int COL_OUT_W = 7;
  localparam int ROW_OUT_W = 5;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [DATA_W-1:0] BLANK_CELL     = 16'h0720;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'd9;

  typedef enum logic [OP_W-1:0] {
    OP_PUT    = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_READ   = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_PUT,
    CMD_NEWLINE,
    CMD_BACKSPACE,
    CMD_TAB,
    CMD_CLEAR,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [CHAR_W-1:0]    char_code;
    logic [ATTR_W-1:0]    attribute;
    logic [INDEX_W-1:0]   cell_index;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FILL,
    ST_DIV,
    ST_RROW,
    ST_RADDR,
    ST_RDATA,
    ST_DONE
  } back_state_t;

endpackage

### hdl/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/tcw_front.sv
// Front end: accepts input items and classifies them into commands.
module tcw_front #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tcw_pkg::OP_W-1:0]     operation,
  input  logic [tcw_pkg::CHAR_W-1:0]   char_code,
  input  logic [tcw_pkg::ATTR_W-1:0]   attribute,
  input  logic [tcw_pkg::INDEX_W-1:0]  cell_index,
  input  logic                         q_full,
  output logic                         q_push,
  output tcw_pkg::cmd_t                q_cmd
);

  localparam int CELLS = COLUMNS * ROWS;

  logic index_ok;

  assign index_ok = 32'(cell_index) < 32'(CELLS);
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd.char_code  = char_code;
    q_cmd.attribute  = attribute;
    q_cmd.cell_index = cell_index;
    case (tcw_pkg::op_t'(operation))
      tcw_pkg::OP_PUT: begin
        case (char_code)
          tcw_pkg::CHAR_NEWLINE:   q_cmd.kind = tcw_pkg::CMD_NEWLINE;
          tcw_pkg::CHAR_BACKSPACE: q_cmd.kind = tcw_pkg::CMD_BACKSPACE;
          tcw_pkg::CHAR_TAB:       q_cmd.kind = tcw_pkg::CMD_TAB;
          default:                 q_cmd.kind = tcw_pkg::CMD_PUT;
        endcase
      end
      tcw_pkg::OP_CLEAR: q_cmd.kind = tcw_pkg::CMD_CLEAR;
      // A read outside the store returns zero and changes nothing.
      tcw_pkg::OP_READ:  q_cmd.kind = index_ok ? tcw_pkg::CMD_READ : tcw_pkg::CMD_NOP;
      default:           q_cmd.kind = tcw_pkg::CMD_NOP;
    endcase
  end

endmodule

### hdl/tcw_queue.sv
// Short command queue between the front end and the back end.
module tcw_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tcw_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output tcw_pkg::cmd_t head
);

  localparam int DEPTH = tcw_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  tcw_pkg::cmd_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign full  = count == (PW+1)'(DEPTH);
  assign valid = count != '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

### hdl/tcw_back.sv
// Back end: owns the cursor, the screen store and its row ring, and builds results.
module tcw_back #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  input  tcw_pkg::cmd_t                   q_cmd,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tcw_pkg::DATA_W-1:0]      read_data,
  output logic [tcw_pkg::COL_OUT_W-1:0]   cursor_column,
  output logic [tcw_pkg::ROW_OUT_W-1:0]   cursor_row,
  output logic                            scrolled
);

  localparam int CW      = $clog2(COLUMNS);
  localparam int RW      = (ROWS > 2) ? $clog2(ROWS) : 1;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int AW      = $clog2(CELLS);
  localparam int IW      = tcw_pkg::INDEX_W;
  localparam int DW      = tcw_pkg::DATA_W;
  localparam int DIV_SHIFT = IW + CW;
  localparam int RECIP_W   = IW + 2;
  localparam int PROD_W    = IW + RECIP_W;
  localparam logic [RECIP_W-1:0] DIV_RECIP =
    RECIP_W'((2 ** DIV_SHIFT + COLUMNS - 1) / COLUMNS);
  localparam logic [CW:0] COLS_WIDE = (CW+1)'(COLUMNS);
  localparam logic [CW:0] TAB_MASK  = ~((CW+1)'(7));
  localparam logic [RW:0] ROWS_WIDE = (RW+1)'(ROWS);

  function automatic logic [RW-1:0] row_inc(input logic [RW-1:0] r);
    return (r == RW'(ROWS - 1)) ? '0 : r + 1'b1;
  endfunction

  tcw_pkg::back_state_t state, state_next;
  tcw_pkg::cmd_t        cmd, cmd_next;

  logic [CW-1:0]     cur_x, cur_x_next;
  logic [RW-1:0]     cur_y, cur_y_next;
  logic [RW-1:0]     cur_prow, cur_prow_next;
  logic [RW-1:0]     top, top_next;
  logic [ROWS-1:0]   row_valid, row_valid_next;
  logic [CW-1:0]     fill_col, fill_col_next;
  logic [IW-1:0]     div_word, div_word_next;
  logic [CW-1:0]     div_rem, div_rem_next;
  logic [RW-1:0]     rd_prow, rd_prow_next;
  logic [DW-1:0]     res_data, res_data_next;
  logic              res_scrolled, res_scrolled_next;
  logic              out_valid_next;
  logic [DW-1:0]     read_data_next;
  logic [tcw_pkg::COL_OUT_W-1:0] cursor_column_next;
  logic [tcw_pkg::ROW_OUT_W-1:0] cursor_row_next;
  logic              scrolled_next;

  logic              out_free;
  logic [AW-1:0]     row_base;
  logic [AW-1:0]     cur_addr;
  logic [AW-1:0]     fill_addr;
  logic [AW-1:0]     rd_addr;
  logic [CW:0]       tab_x;
  logic [PROD_W-1:0] div_prod;
  logic [31:0]       div_back;
  logic [RW:0]       row_sum;
  logic [31:0]       col_wide;
  logic [31:0]       row_wide;

  logic              ram_wr_en;
  logic [AW-1:0]     ram_wr_addr;
  logic [DW-1:0]     ram_wr_data;
  logic              ram_rd_en;
  logic [DW-1:0]     ram_rd_data;

  // Logical rows map onto physical rows through the ring offset held in top.
  assign row_base  = AW'(32'(cur_prow) * 32'(COLUMNS));
  assign cur_addr  = row_base + AW'(cur_x);
  assign fill_addr = row_base + AW'(fill_col);
  assign rd_addr   = AW'(32'(rd_prow) * 32'(COLUMNS)) + AW'(div_rem);
  assign tab_x     = ((CW+1)'(cur_x) + (CW+1)'(8)) & TAB_MASK;
  assign div_prod  = PROD_W'(cmd.cell_index) * PROD_W'(DIV_RECIP);
  assign div_back  = 32'(cmd.cell_index) - 32'(div_word) * 32'(COLUMNS);
  assign row_sum   = (RW+1)'(div_word[RW-1:0]) + (RW+1)'(top);
  assign col_wide  = 32'(cur_x);
  assign row_wide  = 32'(cur_y);
  assign out_free  = !out_valid || !out_stall;

  tcw_ram #(
    .WIDTH(DW),
    .DEPTH(CELLS)
  ) u_cells (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    logic take_nl;
    take_nl            = 1'b0;
    state_next         = state;
    cmd_next           = cmd;
    cur_x_next         = cur_x;
    cur_y_next         = cur_y;
    cur_prow_next      = cur_prow;
    top_next           = top;
    row_valid_next     = row_valid;
    fill_col_next      = fill_col;
    div_word_next      = div_word;
    div_rem_next       = div_rem;
    rd_prow_next       = rd_prow;
    res_data_next      = res_data;
    res_scrolled_next  = res_scrolled;
    out_valid_next     = out_valid && out_stall;
    read_data_next     = read_data;
    cursor_column_next = cursor_column;
    cursor_row_next    = cursor_row;
    scrolled_next      = scrolled;
    q_pop              = 1'b0;
    ram_wr_en          = 1'b0;
    ram_wr_addr        = cur_addr;
    ram_wr_data        = tcw_pkg::BLANK_CELL;
    ram_rd_en          = 1'b0;

    case (state)
      tcw_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          cmd_next   = q_cmd;
          state_next = tcw_pkg::ST_EXEC;
        end
      end

      tcw_pkg::ST_EXEC: begin
        res_data_next     = '0;
        res_scrolled_next = 1'b0;
        state_next        = tcw_pkg::ST_DONE;
        case (cmd.kind)
          tcw_pkg::CMD_PUT: begin
            if (row_valid[cur_prow]) begin
              ram_wr_en   = 1'b1;
              ram_wr_data = {cmd.attribute, cmd.char_code};
              if (cur_x == CW'(COLUMNS - 1)) begin
                take_nl = 1'b1;
              end else begin
                cur_x_next = cur_x + 1'b1;
              end
            end else begin
              // A row that was never written since its last blanking is filled first.
              fill_col_next = '0;
              state_next    = tcw_pkg::ST_FILL;
            end
          end
          tcw_pkg::CMD_NEWLINE: begin
            take_nl = 1'b1;
          end
          tcw_pkg::CMD_BACKSPACE: begin
            if (cur_x != '0) begin
              cur_x_next  = cur_x - 1'b1;
              ram_wr_en   = row_valid[cur_prow];
              ram_wr_addr = cur_addr - 1'b1;
            end
          end
          tcw_pkg::CMD_TAB: begin
            if (tab_x >= COLS_WIDE) begin
              take_nl = 1'b1;
            end else begin
              cur_x_next = tab_x[CW-1:0];
            end
          end
          tcw_pkg::CMD_CLEAR: begin
            row_valid_next = '0;
            top_next       = '0;
            cur_x_next     = '0;
            cur_y_next     = '0;
            cur_prow_next  = '0;
          end
          tcw_pkg::CMD_READ: begin
            state_next = tcw_pkg::ST_DIV;
          end
          default: begin
          end
        endcase

        if (take_nl) begin
          cur_x_next = '0;
          if (cur_y == RW'(ROWS - 1)) begin
            // Scroll: the old top physical row becomes the blank bottom row.
            top_next            = row_inc(top);
            cur_prow_next       = top;
            row_valid_next[top] = 1'b0;
            res_scrolled_next   = 1'b1;
          end else begin
            cur_y_next    = cur_y + 1'b1;
            cur_prow_next = row_inc(cur_prow);
          end
        end
      end

      tcw_pkg::ST_FILL: begin
        ram_wr_en     = 1'b1;
        ram_wr_addr   = fill_addr;
        fill_col_next = fill_col + 1'b1;
        if (fill_col == CW'(COLUMNS - 1)) begin
          row_valid_next[cur_prow] = 1'b1;
          state_next               = tcw_pkg::ST_EXEC;
        end
      end

      tcw_pkg::ST_DIV: begin
        // Row of the cell index by reciprocal multiplication, exact over the index range.
        div_word_next = IW'(div_prod >> DIV_SHIFT);
        state_next    = tcw_pkg::ST_RROW;
      end

      tcw_pkg::ST_RROW: begin
        rd_prow_next = (row_sum >= ROWS_WIDE) ? RW'(row_sum - ROWS_WIDE) : row_sum[RW-1:0];
        div_rem_next = div_back[CW-1:0];
        state_next   = tcw_pkg::ST_RADDR;
      end

      tcw_pkg::ST_RADDR: begin
        ram_rd_en  = 1'b1;
        state_next = tcw_pkg::ST_RDATA;
      end

      tcw_pkg::ST_RDATA: begin
        res_data_next = row_valid[rd_prow] ? ram_rd_data : tcw_pkg::BLANK_CELL;
        state_next    = tcw_pkg::ST_DONE;
      end

      tcw_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_next     = 1'b1;
          read_data_next     = res_data;
          cursor_column_next = col_wide[tcw_pkg::COL_OUT_W-1:0];
          cursor_row_next    = row_wide[tcw_pkg::ROW_OUT_W-1:0];
          scrolled_next      = res_scrolled;
          state_next         = tcw_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tcw_pkg::ST_IDLE;
      cur_x     <= '0;
      cur_y     <= '0;
      cur_prow  <= '0;
      top       <= '0;
      row_valid <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cur_x     <= cur_x_next;
      cur_y     <= cur_y_next;
      cur_prow  <= cur_prow_next;
      top       <= top_next;
      row_valid <= row_valid_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd           <= cmd_next;
    fill_col      <= fill_col_next;
    div_word      <= div_word_next;
    div_rem       <= div_rem_next;
    rd_prow       <= rd_prow_next;
    res_data      <= res_data_next;
    res_scrolled  <= res_scrolled_next;
    read_data     <= read_data_next;
    cursor_column <= cursor_column_next;
    cursor_row    <= cursor_row_next;
    scrolled      <= scrolled_next;
  end

endmodule

### hdl/text_console_writer_core.sv
// Top level of the text console writer: front end, command queue and back end.
//
// Input channel (in_valid / in_stall) takes one item per handshake: put a
// character, clear the screen, or read one cell. Each item yields exactly one
// result on the output channel (out_valid / out_stall): the cell contents for
// a read (zero otherwise), the cursor position after the item, and a flag set
// when the item scrolled the screen up one row.
// For most items the back end pops the item in ST_IDLE, runs it in ST_EXEC
// and registers the result from ST_DONE. The first character written into a
// row that is blank since reset, a clear or a scroll first passes ST_FILL,
// where the back end fills that row of the cell RAM before writing. A read
// passes ST_DIV to find the row of the cell index by reciprocal multiplication,
// then ST_RROW, ST_RADDR and ST_RDATA for address and RAM read. The back end
// works one item at a time; a two-entry queue lets the front end take further
// items meanwhile. Scrolling moves a row ring offset and marks one row blank,
// so it needs no extra state. Reset homes the cursor and marks every row
// blank at once; no clearing pass runs. While the receiver stalls, the result
// register holds and the queue fills, after which in_stall rises.
module text_console_writer_core #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [tcw_pkg::OP_W-1:0]        operation,
  input  logic [tcw_pkg::CHAR_W-1:0]      char_code,
  input  logic [tcw_pkg::ATTR_W-1:0]      attribute,
  input  logic [tcw_pkg::INDEX_W-1:0]     cell_index,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tcw_pkg::DATA_W-1:0]      read_data,
  output logic [tcw_pkg::COL_OUT_W-1:0]   cursor_column,
  output logic [tcw_pkg::ROW_OUT_W-1:0]   cursor_row,
  output logic                            scrolled
);

  logic          q_full;
  logic          q_push;
  logic          q_valid;
  logic          q_pop;
  tcw_pkg::cmd_t push_cmd;
  tcw_pkg::cmd_t head_cmd;

  tcw_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .char_code  (char_code),
    .attribute  (attribute),
    .cell_index (cell_index),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (push_cmd)
  );

  tcw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (head_cmd)
  );

  tcw_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_cmd         (head_cmd),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .read_data     (read_data),
    .cursor_column (cursor_column),
    .cursor_row    (cursor_row),
    .scrolled      (scrolled)
  );

  // The back end only takes a command when the queue holds one.
  a_pop_nonempty : assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("command taken from an empty queue");

  // A scroll always leaves the cursor at the start of the last row.
  a_scroll_column : assert property (@(posedge clk) disable iff (rst)
    (out_valid && scrolled) |-> (cursor_column == '0))
    else $error("scroll result with cursor off column zero");

  a_scroll_row : assert property (@(posedge clk) disable iff (rst)
    (out_valid && scrolled) |-> (cursor_row == tcw_pkg::ROW_OUT_W'(ROWS - 1)))
    else $error("scroll result with cursor off the last row");

endmodule
